// ----- hdl/bgcf_pkg.sv -----
// ----------------------------------------------------------------------------
// bgcf_pkg
// Shared types and constants of the binary grid corner finder.
// ----------------------------------------------------------------------------
package bgcf_pkg;

    localparam int MaxWidth   = 2048;
    localparam int MaxCorners = 256;
    localparam int ColAw      = $clog2(MaxWidth);
    localparam int TblAw      = $clog2(MaxCorners);
    localparam int CntW       = TblAw + 1;
    localparam int XW         = 11;
    localparam int YW         = 12;
    localparam int RunW       = 12;

    localparam logic [2:0] CFG_IMAGE_WIDTH   = 3'd0;
    localparam logic [2:0] CFG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [2:0] CFG_EDGE_MIN_RUN  = 3'd2;
    localparam logic [2:0] CFG_CROSS_MIN_RUN = 3'd3;
    localparam logic [2:0] CFG_DEDUP_RADIUS  = 3'd4;
    localparam logic [2:0] CFG_ANCHOR_MARGIN = 3'd5;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_EVAL,
        S_START,
        S_SCAN,
        S_EMIT,
        S_FLUSH
    } state_t;

    typedef enum logic [1:0] {
        P_EDGE,
        P_CROSS_I,
        P_CROSS_TOP,
        P_MIRROR
    } phase_t;

    typedef struct packed {
        logic          start;
        logic [XW-1:0] x;
        logic [YW-1:0] y;
    } dd_req_t;

    typedef struct packed {
        logic done;
        logic near;
    } dd_rsp_t;

    typedef struct packed {
        logic             en;
        logic [TblAw-1:0] addr;
        logic [XW-1:0]    x;
        logic [YW-1:0]    y;
    } tbl_wr_t;

endpackage

// ----- hdl/bgcf_dedup.sv -----
// ----------------------------------------------------------------------------
// bgcf_dedup
// Corner table with a sequential proximity scan over the stored corners.
// ----------------------------------------------------------------------------
module bgcf_dedup
    import bgcf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  dd_req_t          req,
    input  tbl_wr_t          wr,
    input  logic [CntW-1:0]  count,
    input  logic [11:0]      radius,
    output dd_rsp_t          rsp
);

    logic [XW+YW-1:0] tbl_mem [MaxCorners];
    logic [XW+YW-1:0] rd_data_reg;
    logic             busy_reg, busy_next;
    logic             rd_v_reg, rd_v_next;
    logic [CntW-1:0]  scan_k_reg, scan_k_next;
    logic [XW-1:0]    x_reg;
    logic [YW-1:0]    y_reg;
    logic             rd_en;
    logic [XW-1:0]    ex;
    logic [YW-1:0]    ey;
    logic             hit;

    assign ex = rd_data_reg[XW+YW-1:YW];
    assign ey = rd_data_reg[YW-1:0];

    assign hit = rd_v_reg
        && ({2'b0, ex} < ({2'b0, x_reg} + {1'b0, radius}))
        && (({2'b0, ex} + {1'b0, radius}) >= {2'b0, x_reg})
        && ({1'b0, ey} < ({1'b0, y_reg} + {1'b0, radius}))
        && (({1'b0, ey} + {1'b0, radius}) > {1'b0, y_reg})
        && (ey != '0);

    always_comb
    begin
        busy_next   = busy_reg;
        rd_v_next   = 1'b0;
        scan_k_next = scan_k_reg;
        rd_en       = 1'b0;
        rsp         = '0;
        if (req.start)
        begin
            busy_next   = 1'b1;
            scan_k_next = '0;
        end
        else if (busy_reg)
        begin
            if (hit)
            begin
                rsp.done  = 1'b1;
                rsp.near  = 1'b1;
                busy_next = 1'b0;
            end
            else if (scan_k_reg < count)
            begin
                rd_en       = 1'b1;
                rd_v_next   = 1'b1;
                scan_k_next = scan_k_reg + 1'b1;
            end
            else
            begin
                rsp.done  = 1'b1;
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            rd_v_reg   <= 1'b0;
            scan_k_reg <= '0;
        end
        else
        begin
            busy_reg   <= busy_next;
            rd_v_reg   <= rd_v_next;
            scan_k_reg <= scan_k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg <= req.x;
            y_reg <= req.y;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
            tbl_mem[wr.addr] <= {wr.x, wr.y};
        if (rd_en)
            rd_data_reg <= tbl_mem[scan_k_reg[TblAw-1:0]];
    end

endmodule

// ----- hdl/binary_grid_corner_finder_top.sv -----
// ----------------------------------------------------------------------------
// binary_grid_corner_finder_top
// Streaming corner finder for binary raster images.
// ----------------------------------------------------------------------------
// Each item is accepted in S_IDLE, read in S_RD and evaluated in S_EVAL; an item without
// candidates then passes S_FLUSH. Each candidate passes S_START and a scan of the stored
// corners in S_SCAN, then S_EMIT unless one is near; the last result leaves from S_FLUSH.
// A frame_start item first clears the 2048-entry run buffer.
// Reset is asynchronous active low; afterwards the run buffer is cleared before the
// first item is accepted.
// ----------------------------------------------------------------------------
module binary_grid_corner_finder_top
    import bgcf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
    input  logic [0:0]  s_axis_tuser,   // [0] frame_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [10:0] corner_x, [22:11] corner_y, [23] zero
    output logic        m_axis_tlast,
    output logic [0:0]  m_axis_tuser,   // [0] not_recorded
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_data
);

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    logic [11:0] width_reg, edge_min_reg, cross_min_reg, radius_reg, margin_reg;
    logic [12:0] height_reg;

    logic [RunW-1:0]  col_mem [MaxWidth];
    logic [RunW-1:0]  col_rdata_reg;
    logic             col_we;
    logic [ColAw-1:0] col_waddr;
    logic [RunW-1:0]  col_wdata;
    logic [ColAw-1:0] clr_cnt_reg, clr_cnt_next;
    logic             clr_item_reg, clr_item_next;

    logic [ColAw-1:0] col_pos_reg, col_pos_next;
    logic [YW-1:0]    row_pos_reg, row_pos_next;
    logic [RunW-1:0]  row_run_reg, row_run_next;
    logic [CntW-1:0]  count_reg, count_next;
    logic             pix_on_reg, pix_on_next;

    logic [XW-1:0] j_reg, j_next, mx_reg, mx_next, try_x_reg, try_x_next;
    logic [YW-1:0] i_reg, i_next, top_reg, top_next, try_y_reg, try_y_next;
    logic          near_edge_reg, near_edge_next;

    logic          pend_v_reg, pend_v_next;
    logic [XW-1:0] pend_x_reg, pend_x_next;
    logic [YW-1:0] pend_y_reg, pend_y_next;
    logic          pend_nr_reg, pend_nr_next;

    logic          out_v_reg, out_v_next;
    logic [XW-1:0] out_x_reg, out_x_next;
    logic [YW-1:0] out_y_reg, out_y_next;
    logic          out_last_reg, out_last_next;
    logic          out_nr_reg, out_nr_next;
    logic          out_free;

    logic          in_acc;
    dd_req_t       dd_req;
    dd_rsp_t       dd_rsp;
    tbl_wr_t       tbl_wr;

    logic          ev_on;
    logic [11:0]   w_eff;
    logic [12:0]   h_eff;
    logic          row_is_last, edge_hit, cross_hit, ev_near;
    logic [YW-1:0] ev_top;
    logic [XW-1:0] ev_mx;
    logic [11:0]   mx_diff;
    logic [RunW-1:0] vcur, hcur;

    logic          kept;
    logic          nx_valid;
    phase_t        nx_phase;
    logic [XW-1:0] nx_x;
    logic [YW-1:0] nx_y;

    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_v_reg || m_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {1'b0, out_y_reg, out_x_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_nr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= 12'd640;
            height_reg    <= 13'd480;
            edge_min_reg  <= 12'd100;
            cross_min_reg <= 12'd40;
            radius_reg    <= 12'd40;
            margin_reg    <= 12'd10;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:   width_reg     <= cfg_data[11:0];
                CFG_IMAGE_HEIGHT:  height_reg    <= cfg_data;
                CFG_EDGE_MIN_RUN:  edge_min_reg  <= cfg_data[11:0];
                CFG_CROSS_MIN_RUN: cross_min_reg <= cfg_data[11:0];
                CFG_DEDUP_RADIUS:  radius_reg    <= cfg_data[11:0];
                CFG_ANCHOR_MARGIN: margin_reg    <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        ev_on    = pix_on_reg;
        w_eff    = (width_reg > 12'(MaxWidth)) ? 12'(MaxWidth)
                 : ((width_reg == '0) ? 12'd1 : width_reg);
        h_eff    = (height_reg == '0) ? 13'd1 : height_reg;
        row_is_last = ({1'b0, row_pos_reg} == (h_eff - 13'd1));
        ev_top   = (row_pos_reg >= col_rdata_reg) ? (row_pos_reg - col_rdata_reg) : '0;
        ev_near  = ({2'b0, col_pos_reg} + {1'b0, margin_reg}) >= {1'b0, w_eff};
        mx_diff  = w_eff - {1'b0, col_pos_reg};
        if ({1'b0, col_pos_reg} > w_eff)
            ev_mx = '0;
        else if (mx_diff > 12'(MaxWidth - 1))
            ev_mx = XW'(MaxWidth - 1);
        else
            ev_mx = mx_diff[XW-1:0];
        vcur = !ev_on ? '0 : ((col_rdata_reg == '1) ? col_rdata_reg : col_rdata_reg + 1'b1);
        hcur = !ev_on ? '0 : ((row_run_reg == '1) ? row_run_reg : row_run_reg + 1'b1);
        edge_hit  = (!ev_on || row_is_last) && (col_rdata_reg > edge_min_reg);
        cross_hit = !edge_hit && (col_rdata_reg > cross_min_reg)
                    && (row_run_reg > cross_min_reg);
    end

    always_comb
    begin
        kept     = (state_reg == S_EMIT);
        nx_valid = 1'b0;
        nx_phase = P_MIRROR;
        nx_x     = mx_reg;
        nx_y     = top_reg;
        case (phase_reg)
            P_EDGE:
                nx_valid = near_edge_reg;
            P_CROSS_I:
            begin
                if (kept)
                begin
                    nx_valid = 1'b1;
                    nx_phase = P_CROSS_TOP;
                    nx_x     = j_reg;
                end
                else
                begin
                    nx_valid = near_edge_reg;
                    nx_y     = i_reg;
                end
            end
            P_CROSS_TOP:
                nx_valid = near_edge_reg;
            default:
                nx_valid = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
                if (clr_cnt_reg == '1)
                    state_next = clr_item_reg ? S_RD : S_IDLE;
            S_IDLE:
                if (in_acc)
                    state_next = s_axis_tuser[0] ? S_CLEAR : S_RD;
            S_RD:
                state_next = S_EVAL;
            S_EVAL:
                state_next = (edge_hit || cross_hit) ? S_START : S_FLUSH;
            S_START:
                state_next = S_SCAN;
            S_SCAN:
                if (dd_rsp.done)
                    state_next = dd_rsp.near ? (nx_valid ? S_START : S_FLUSH) : S_EMIT;
            S_EMIT:
                if (out_free)
                    state_next = nx_valid ? S_START : S_FLUSH;
            S_FLUSH:
                if (!pend_v_reg || out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready  = (state_reg == S_IDLE);
        clr_cnt_next   = clr_cnt_reg;
        clr_item_next  = clr_item_reg;
        col_pos_next   = col_pos_reg;
        row_pos_next   = row_pos_reg;
        row_run_next   = row_run_reg;
        count_next     = count_reg;
        pix_on_next    = pix_on_reg;
        phase_next     = phase_reg;
        j_next         = j_reg;
        i_next         = i_reg;
        mx_next        = mx_reg;
        top_next       = top_reg;
        near_edge_next = near_edge_reg;
        try_x_next     = try_x_reg;
        try_y_next     = try_y_reg;
        pend_v_next    = pend_v_reg;
        pend_x_next    = pend_x_reg;
        pend_y_next    = pend_y_reg;
        pend_nr_next   = pend_nr_reg;
        out_v_next     = out_v_reg && !m_axis_tready;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_last_next  = out_last_reg;
        out_nr_next    = out_nr_reg;
        col_we         = 1'b0;
        col_waddr      = col_pos_reg;
        col_wdata      = vcur;
        dd_req         = '0;
        dd_req.x       = try_x_reg;
        dd_req.y       = try_y_reg;
        tbl_wr         = '0;
        tbl_wr.addr    = count_reg[TblAw-1:0];
        tbl_wr.x       = try_x_reg;
        tbl_wr.y       = try_y_reg;
        case (state_reg)
            S_CLEAR:
            begin
                col_we       = 1'b1;
                col_waddr    = clr_cnt_reg;
                col_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    pix_on_next = |s_axis_tdata;
                    if (s_axis_tuser[0])
                    begin
                        clr_item_next = 1'b1;
                        clr_cnt_next  = '0;
                        col_pos_next  = '0;
                        row_pos_next  = '0;
                        row_run_next  = '0;
                        count_next    = '0;
                    end
                end
            end
            S_EVAL:
            begin
                col_we         = 1'b1;
                j_next         = col_pos_reg;
                i_next         = row_pos_reg;
                mx_next        = ev_mx;
                top_next       = ev_top;
                near_edge_next = ev_near;
                phase_next     = edge_hit ? P_EDGE : P_CROSS_I;
                try_x_next     = col_pos_reg;
                try_y_next     = edge_hit ? ev_top : row_pos_reg;
                if (({1'b0, col_pos_reg} + 12'd1) >= w_eff)
                begin
                    col_pos_next = '0;
                    row_run_next = '0;
                    row_pos_next = (({1'b0, row_pos_reg} + 13'd1) >= h_eff)
                                 ? '0 : (row_pos_reg + 1'b1);
                end
                else
                begin
                    col_pos_next = col_pos_reg + 1'b1;
                    row_run_next = hcur;
                end
            end
            S_START:
                dd_req.start = 1'b1;
            S_SCAN:
            begin
                if (dd_rsp.done && dd_rsp.near && nx_valid)
                begin
                    phase_next = nx_phase;
                    try_x_next = nx_x;
                    try_y_next = nx_y;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    if (pend_v_reg)
                    begin
                        out_v_next    = 1'b1;
                        out_x_next    = pend_x_reg;
                        out_y_next    = pend_y_reg;
                        out_last_next = 1'b0;
                        out_nr_next   = pend_nr_reg;
                    end
                    pend_v_next  = 1'b1;
                    pend_x_next  = try_x_reg;
                    pend_y_next  = try_y_reg;
                    pend_nr_next = count_reg[CntW-1];
                    if (!count_reg[CntW-1])
                    begin
                        tbl_wr.en  = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    if (nx_valid)
                    begin
                        phase_next = nx_phase;
                        try_x_next = nx_x;
                        try_y_next = nx_y;
                    end
                end
            end
            S_FLUSH:
            begin
                clr_item_next = 1'b0;
                if (pend_v_reg && out_free)
                begin
                    out_v_next    = 1'b1;
                    out_x_next    = pend_x_reg;
                    out_y_next    = pend_y_reg;
                    out_last_next = 1'b1;
                    out_nr_next   = pend_nr_reg;
                    pend_v_next   = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            clr_item_reg <= 1'b0;
            col_pos_reg  <= '0;
            row_pos_reg  <= '0;
            row_run_reg  <= '0;
            count_reg    <= '0;
            pend_v_reg   <= 1'b0;
            out_v_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            clr_item_reg <= clr_item_next;
            col_pos_reg  <= col_pos_next;
            row_pos_reg  <= row_pos_next;
            row_run_reg  <= row_run_next;
            count_reg    <= count_next;
            pend_v_reg   <= pend_v_next;
            out_v_reg    <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_on_reg    <= pix_on_next;
        phase_reg     <= phase_next;
        j_reg         <= j_next;
        i_reg         <= i_next;
        mx_reg        <= mx_next;
        top_reg       <= top_next;
        near_edge_reg <= near_edge_next;
        try_x_reg     <= try_x_next;
        try_y_reg     <= try_y_next;
        pend_x_reg    <= pend_x_next;
        pend_y_reg    <= pend_y_next;
        pend_nr_reg   <= pend_nr_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_last_reg  <= out_last_next;
        out_nr_reg    <= out_nr_next;
    end

    always_ff @(posedge clk)
    begin
        if (col_we)
            col_mem[col_waddr] <= col_wdata;
        col_rdata_reg <= col_mem[col_pos_reg];
    end

    bgcf_dedup u_dedup
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (dd_req),
        .wr     (tbl_wr),
        .count  (count_reg),
        .radius (radius_reg),
        .rsp    (dd_rsp)
    );

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(MaxCorners))
        else $error("corner count above table size");

    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !pend_v_reg)
        else $error("pending result left when taking a new item");

    a_store_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_wr.en |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("table write without count advance");

endmodule
